// ----- rtl/mrrc_pkg.sv -----
// ----------------------------------------------------------------------------
// mrrc_pkg
// Shared types and constants of the memory range region check block.
// ----------------------------------------------------------------------------
`default_nettype none

package mrrc_pkg;

  localparam int unsigned AreaDepth   = 256;
  localparam int unsigned RegionDepth = 64;
  localparam int unsigned AreaAw      = $clog2(AreaDepth);
  localparam int unsigned RegionAw    = $clog2(RegionDepth);
  // search index width: holds counts up to the larger table depth
  localparam int unsigned IdxW        = 10;

  localparam logic [1:0] OpWrArea   = 2'd0;
  localparam logic [1:0] OpWrRegion = 2'd1;
  localparam logic [1:0] OpQuery    = 2'd2;

  // classified work handed from front to back
  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  index;
    logic [31:0] start;
    logic [31:0] size;
    logic [31:0] flags;
    logic [31:0] lo;
    logic [31:0] hi;
    logic        part;
    logic [7:0]  offset;
    logic [9:0]  count;
  } cmd_t;

endpackage

`default_nettype wire

// ----- rtl/mrrc_ram.sv -----
// ----------------------------------------------------------------------------
// mrrc_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module mrrc_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ----- rtl/mrrc_front.sv -----
// ----------------------------------------------------------------------------
// mrrc_front
// Accepts input transactions, classifies them and queues them for the back.
// ----------------------------------------------------------------------------
`default_nettype none

module mrrc_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_valid_i,
  output logic                s_ready_o,
  input  logic [1:0]          operation_i,
  input  logic [7:0]          entry_index_i,
  input  logic [31:0]         entry_start_i,
  input  logic [31:0]         entry_size_i,
  input  logic [31:0]         entry_flags_i,
  input  logic [31:0]         query_addr_i,
  input  logic [31:0]         query_len_i,
  input  logic                by_partition_i,
  input  logic [7:0]          area_offset_i,
  input  logic [8:0]          area_count_i,
  input  logic [6:0]          region_count_i,
  output logic                q_valid_o,
  input  logic                q_ready_i,
  output mrrc_pkg::cmd_t      q_cmd_o
);
  import mrrc_pkg::*;

  cmd_t        cmd;
  cmd_t        slot_q [2];
  logic [1:0]  fill_q, fill_d;
  logic        wp_q, rp_q;
  logic        push, pop;
  logic [9:0]  cnt;

  // clamp search count to the selected table
  always_comb begin
    if (by_partition_i) begin
      cnt = (area_count_i > 9'(AreaDepth)) ? 10'(AreaDepth) : {1'b0, area_count_i};
    end else begin
      cnt = (region_count_i > 7'(RegionDepth)) ? 10'(RegionDepth)
                                                : {3'b0, region_count_i};
    end
    cmd.op     = operation_i;
    cmd.index  = entry_index_i;
    cmd.start  = entry_start_i;
    cmd.size   = entry_size_i;
    cmd.flags  = entry_flags_i;
    cmd.lo     = query_addr_i;
    cmd.hi     = query_addr_i + query_len_i - 32'd1;
    cmd.part   = by_partition_i;
    cmd.offset = area_offset_i;
    cmd.count  = cnt;
  end

  assign s_ready_o = (fill_q != 2'd2);
  // drop the unused operation code at the door
  assign push      = s_valid_i && s_ready_o && (operation_i != 2'd3);
  assign pop       = q_valid_o && q_ready_i;
  assign q_valid_o = (fill_q != 2'd0);
  assign q_cmd_o   = slot_q[rp_q];

  always_comb begin
    fill_d = fill_q;
    if (push && !pop) fill_d = fill_q + 2'd1;
    if (!push && pop) fill_d = fill_q - 2'd1;
  end

  // two-entry queue control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= 2'd0;
      wp_q   <= 1'b0;
      rp_q   <= 1'b0;
    end else begin
      fill_q <= fill_d;
      if (push) wp_q <= ~wp_q;
      if (pop)  rp_q <= ~rp_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) slot_q[wp_q] <= cmd;
  end

  a_fill_max: assert property (@(posedge clk_i) disable iff (!rst_ni) fill_q <= 2'd2)
    else $error("queue overfilled");
  a_full_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q == 2'd0 || fill_q == 2'd2) |-> (wp_q == rp_q))
    else $error("queue pointers disagree with fill");
  a_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q == 2'd2 && !pop) |=> (fill_q == 2'd2))
    else $error("full queue lost entry");

endmodule

`default_nettype wire

// ----- rtl/mrrc_back.sv -----
// ----------------------------------------------------------------------------
// mrrc_back
// Executes table writes and runs the binary search for range queries.
// ----------------------------------------------------------------------------
`default_nettype none

module mrrc_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  output logic           q_ready_o,
  input  mrrc_pkg::cmd_t q_cmd_i,
  output logic           res_valid_o,
  input  logic           res_ready_i,
  output logic           res_found_o,
  output logic [31:0]    res_flags_o
);
  import mrrc_pkg::*;

  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StRead = 4'b0010,
    StTest = 4'b0100,
    StDone = 4'b1000
  } state_e;

  state_e       state_q, state_d;
  cmd_t         cmd_q;
  logic signed [IdxW:0] l_q, l_d, r_q, r_d, c;
  logic         found_q, found_d;
  logic [31:0]  flags_q, flags_d;
  logic         take;
  logic [31:0]  a_st, a_sz, a_fl, r_st, r_sz, r_fl;
  logic [31:0]  e_st, e_fl, e_end;
  logic [AreaAw-1:0]   a_raddr;
  logic [RegionAw-1:0] r_raddr;
  logic         we_a, we_r;

  assign take  = q_valid_i && q_ready_o;
  assign c     = (l_q + r_q) >>> 1;
  assign we_a  = take && q_cmd_i.op == OpWrArea
                 && {1'b0, q_cmd_i.index} < 9'(AreaDepth);
  assign we_r  = take && q_cmd_i.op == OpWrRegion && {1'b0, q_cmd_i.index} < 9'(RegionDepth);
  assign a_raddr = cmd_q.offset + c[AreaAw-1:0];
  assign r_raddr = c[RegionAw-1:0];

  mrrc_ram #(.Width(32), .Depth(AreaDepth)) u_a_st (.clk_i, .we_i(we_a),
    .waddr_i(q_cmd_i.index[AreaAw-1:0]), .wdata_i(q_cmd_i.start),
    .raddr_i(a_raddr), .rdata_o(a_st));
  mrrc_ram #(.Width(32), .Depth(AreaDepth)) u_a_sz (.clk_i, .we_i(we_a),
    .waddr_i(q_cmd_i.index[AreaAw-1:0]), .wdata_i(q_cmd_i.size),
    .raddr_i(a_raddr), .rdata_o(a_sz));
  mrrc_ram #(.Width(32), .Depth(AreaDepth)) u_a_fl (.clk_i, .we_i(we_a),
    .waddr_i(q_cmd_i.index[AreaAw-1:0]), .wdata_i(q_cmd_i.flags),
    .raddr_i(a_raddr), .rdata_o(a_fl));
  mrrc_ram #(.Width(32), .Depth(RegionDepth)) u_r_st (.clk_i, .we_i(we_r),
    .waddr_i(q_cmd_i.index[RegionAw-1:0]), .wdata_i(q_cmd_i.start),
    .raddr_i(r_raddr), .rdata_o(r_st));
  mrrc_ram #(.Width(32), .Depth(RegionDepth)) u_r_sz (.clk_i, .we_i(we_r),
    .waddr_i(q_cmd_i.index[RegionAw-1:0]), .wdata_i(q_cmd_i.size),
    .raddr_i(r_raddr), .rdata_o(r_sz));
  mrrc_ram #(.Width(32), .Depth(RegionDepth)) u_r_fl (.clk_i, .we_i(we_r),
    .waddr_i(q_cmd_i.index[RegionAw-1:0]), .wdata_i(q_cmd_i.flags),
    .raddr_i(r_raddr), .rdata_o(r_fl));

  assign e_st  = cmd_q.part ? a_st : r_st;
  assign e_fl  = cmd_q.part ? a_fl : r_fl;
  assign e_end = e_st + (cmd_q.part ? a_sz : r_sz) - 32'd1;

  assign q_ready_o   = (state_q == StIdle);
  assign res_valid_o = (state_q == StDone);
  assign res_found_o = found_q;
  assign res_flags_o = flags_q;

  // search sequencer: read an entry, test it, narrow the window
  always_comb begin
    state_d = state_q;
    l_d = l_q;
    r_d = r_q;
    found_d = found_q;
    flags_d = flags_q;
    case (state_q)
      StIdle: begin
        if (take && q_cmd_i.op == OpQuery) begin
          l_d = '0;
          r_d = $signed({1'b0, q_cmd_i.count}) - 11'sd1;
          found_d = 1'b0;
          flags_d = '0;
          state_d = (q_cmd_i.count == 10'd0) ? StDone : StRead;
        end
      end
      StRead: state_d = StTest;
      StTest: begin
        if (cmd_q.lo < e_st) begin
          r_d = c - 11'sd1;
        end else if (cmd_q.hi > e_end) begin
          l_d = c + 11'sd1;
        end else begin
          found_d = 1'b1;
          flags_d = e_fl;
        end
        if (found_d || l_d > r_d) state_d = StDone;
        else state_d = StRead;
      end
      StDone: if (res_ready_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) cmd_q <= q_cmd_i;
    l_q <= l_d;
    r_q <= r_d;
    found_q <= found_d;
    flags_q <= flags_d;
  end

  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(state_q))
    else $error("state not one-hot");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_ready_i) |=> (res_valid_o && $stable(res_flags_o)))
    else $error("result dropped under stall");
  a_nf_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_found_o) |-> (res_flags_o == 32'd0))
    else $error("flags set without match");

endmodule

`default_nettype wire

// ----- rtl/memory_range_region_check_top.sv -----
// ----------------------------------------------------------------------------
// memory_range_region_check_top
// Range check of an address span against sorted area and region tables.
// ----------------------------------------------------------------------------
// Usage: input transactions arrive on s_axis (tuser = operation). Writes fill
// at most one table slot and give no output; queries produce one m_axis
// transaction with found in tuser and match_flags in tdata. region_count_we_i
// loads the region count register; the user must do so only while the block
// is idle, as the block itself does not enforce it. A query probes entries
// one at a time, each with a registered RAM read and then a compare. The
// search loop sets the rate: one item at a time. A two-entry queue lets the
// front take items while a result is stalled. Reset clears the queue, the
// sequencer and region_count; table contents are undefined until written.
// When m_axis_tready is low the result holds and the back end waits; the
// front keeps filling its queue.
// ----------------------------------------------------------------------------
`default_nettype none

module memory_range_region_check_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // tdata: entry_index[7:0], entry_start[39:8], entry_size[71:40],
  // entry_flags[103:72], query_addr[135:104], query_len[167:136],
  // by_partition[168], area_offset[176:169], area_count[185:177]
  input  logic [191:0]  s_axis_tdata,
  input  logic [1:0]    s_axis_tuser, // operation[1:0]
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [31:0]   m_axis_tdata, // match_flags[31:0]
  output logic          m_axis_tuser, // found[0]
  input  logic          region_count_we_i,
  input  logic [6:0]    region_count_i
);
  import mrrc_pkg::*;

  logic       q_valid, q_ready;
  cmd_t       q_cmd;
  logic [6:0] region_count_q;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      region_count_q <= 7'd0;
    end else if (region_count_we_i) begin
      region_count_q <= region_count_i;
    end
  end

  mrrc_front u_front (
    .clk_i, .rst_ni,
    .s_valid_i(s_axis_tvalid), .s_ready_o(s_axis_tready),
    .operation_i(s_axis_tuser),
    .entry_index_i(s_axis_tdata[7:0]),
    .entry_start_i(s_axis_tdata[39:8]),
    .entry_size_i(s_axis_tdata[71:40]),
    .entry_flags_i(s_axis_tdata[103:72]),
    .query_addr_i(s_axis_tdata[135:104]),
    .query_len_i(s_axis_tdata[167:136]),
    .by_partition_i(s_axis_tdata[168]),
    .area_offset_i(s_axis_tdata[176:169]),
    .area_count_i(s_axis_tdata[185:177]),
    .region_count_i(region_count_q),
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_cmd_o(q_cmd)
  );

  mrrc_back u_back (
    .clk_i, .rst_ni,
    .q_valid_i(q_valid), .q_ready_o(q_ready), .q_cmd_i(q_cmd),
    .res_valid_o(m_axis_tvalid), .res_ready_i(m_axis_tready),
    .res_found_o(m_axis_tuser), .res_flags_o(m_axis_tdata)
  );

endmodule

`default_nettype wire

// ----- tb/mrrc_checker.sv -----
// ----------------------------------------------------------------------------
// mrrc_checker
// Predicts range check results from the observed input and configuration
// traffic and compares them with every output transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module mrrc_checker
  import mrrc_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [191:0] s_axis_tdata,
  input  logic [1:0]   s_axis_tuser,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [31:0]  m_axis_tdata,
  input  logic         m_axis_tuser,
  input  logic         region_count_we_i,
  input  logic [6:0]   region_count_i,
  output int           pending_o,
  output int           fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic        found;
    logic [31:0] flags;
  } check_res_t;

  logic [31:0] area_start [AreaDepth];
  logic [31:0] area_size  [AreaDepth];
  logic [31:0] area_flags [AreaDepth];
  logic [31:0] reg_start  [RegionDepth];
  logic [31:0] reg_size   [RegionDepth];
  logic [31:0] reg_flags  [RegionDepth];
  logic [6:0]  region_count;

  check_res_t  result_queue [$];

  // binary search of the chosen table for an entry that holds [lo, hi]
  function automatic check_res_t search_range(logic [31:0] lo, logic [31:0] len,
                                              logic part, logic [7:0] off,
                                              logic [8:0] cnt_in);
    check_res_t  res;
    logic [31:0] hi, a, b, fl;
    int          cnt, l, r, c;
    res.found = 1'b0;
    res.flags = '0;
    hi = lo + len - 32'd1;
    if (part) cnt = (cnt_in > AreaDepth) ? AreaDepth : cnt_in;
    else cnt = (region_count > RegionDepth) ? RegionDepth : region_count;
    l = 0;
    r = cnt - 1;
    while (l <= r) begin
      c = (l + r) / 2;
      if (part) begin
        a  = area_start[(off + c) % AreaDepth];
        b  = a + area_size[(off + c) % AreaDepth] - 32'd1;
        fl = area_flags[(off + c) % AreaDepth];
      end else begin
        a  = reg_start[c];
        b  = a + reg_size[c] - 32'd1;
        fl = reg_flags[c];
      end
      if (lo < a) r = c - 1;
      else if (hi > b) l = c + 1;
      else begin
        res.found = 1'b1;
        res.flags = fl;
        break;
      end
    end
    return res;
  endfunction

  // track writes and queries, compare outputs against the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin
    check_res_t want;
    if (!rst_ni) begin
      region_count = '0;
      result_queue.delete();
      fail_count_o = 0;
    end else begin
      if (region_count_we_i) region_count = region_count_i;
      if (s_axis_tvalid && s_axis_tready) begin
        case (s_axis_tuser)
          OpWrArea: begin
            area_start[s_axis_tdata[7:0]] = s_axis_tdata[39:8];
            area_size[s_axis_tdata[7:0]]  = s_axis_tdata[71:40];
            area_flags[s_axis_tdata[7:0]] = s_axis_tdata[103:72];
          end
          OpWrRegion: begin
            if (s_axis_tdata[7:0] < RegionDepth) begin
              reg_start[s_axis_tdata[5:0]] = s_axis_tdata[39:8];
              reg_size[s_axis_tdata[5:0]]  = s_axis_tdata[71:40];
              reg_flags[s_axis_tdata[5:0]] = s_axis_tdata[103:72];
            end
          end
          OpQuery: begin
            result_queue.push_back(search_range(s_axis_tdata[135:104],
                s_axis_tdata[167:136], s_axis_tdata[168], s_axis_tdata[176:169],
                s_axis_tdata[185:177]));
          end
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (result_queue.size() == 0) begin
          $display("%0t: unexpected result found=%0b flags=%h", $realtime,
                   m_axis_tuser, m_axis_tdata);
          fail_count_o++;
        end else begin
          want = result_queue.pop_front();
          if (want.found !== m_axis_tuser) begin
            $display("%0t: found mismatch expected %0b actual %0b", $realtime,
                     want.found, m_axis_tuser);
            fail_count_o++;
          end
          if (want.flags !== m_axis_tdata) begin
            $display("%0t: flags mismatch expected %h actual %h", $realtime,
                     want.flags, m_axis_tdata);
            fail_count_o++;
          end
        end
      end
    end
    pending_o = result_queue.size();
  end

endmodule

`default_nettype wire

// ----- tb/memory_range_region_check_top_tb.sv -----
// ----------------------------------------------------------------------------
// memory_range_region_check_top_tb
// Stimulus and verdict for the range check block: builds sorted tables,
// sends directed and random queries under varying backpressure, and lets
// the checker compare every result.
// ----------------------------------------------------------------------------
`default_nettype none

module memory_range_region_check_top_tb;
  import mrrc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 1000000;
  localparam int QuietCycles = 40;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [191:0] s_axis_tdata = '0;
  logic [1:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [31:0]  m_axis_tdata;
  logic         m_axis_tuser;
  logic         region_count_we_i = 1'b0;
  logic [6:0]   region_count_i = '0;
  int           pending;
  int           fail_count;

  int           tx_idle_pct = 0;
  int           rx_idle_pct = 0;
  int           hold_len = 0;
  int           cycles = 0;
  int           queries_sent = 0;

  // layout copy used only to aim queries at real entries
  logic [31:0]  area_start [AreaDepth];
  logic [31:0]  area_size  [AreaDepth];
  logic [31:0]  reg_start  [RegionDepth];
  logic [31:0]  reg_size   [RegionDepth];

  memory_range_region_check_top u_dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .s_axis_tuser, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .m_axis_tuser, .region_count_we_i, .region_count_i
  );

  mrrc_checker u_checker (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .s_axis_tuser, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .m_axis_tuser, .region_count_we_i, .region_count_i,
    .pending_o(pending), .fail_count_o(fail_count)
  );

  always #1 clk_i = ~clk_i;

  // drop the run if it hangs
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("TB_ERROR");
      $finish;
    end
  end

  // receiver: random stalls, or a long hold-off when requested
  always @(posedge clk_i) begin
    if (hold_len > 0) begin
      m_axis_tready <= 1'b0;
      hold_len = hold_len - 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // send one transaction, idling first at the current sender rate
  task automatic push(logic [1:0] op, logic [191:0] data);
    int gap;
    gap = 0;
    while (gap < 30 && $urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= data;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (op == OpQuery) queries_sent++;
  endtask

  task automatic write_entry(logic [1:0] op, logic [7:0] idx, logic [31:0] st,
                             logic [31:0] sz, logic [31:0] fl);
    push(op, {88'd0, fl, sz, st, idx});
  endtask

  task automatic query(logic [31:0] addr, logic [31:0] len, logic part,
                       logic [7:0] off, logic [8:0] cnt);
    push(OpQuery, {6'd0, cnt, off, part, len, addr, 104'd0});
  endtask

  // wait until the block is idle, then load the region count
  task automatic set_region_count(logic [6:0] value);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (QuietCycles) @(posedge clk_i);
    region_count_we_i <= 1'b1;
    region_count_i    <= value;
    @(posedge clk_i);
    region_count_we_i <= 1'b0;
  endtask

  // fill both tables with consecutive, non-overlapping entries (sorted unless the addresses wrap)
  task automatic build_tables(logic [31:0] base, int max_gap, int max_size);
    logic [31:0] cur;
    cur = base;
    for (int i = 0; i < AreaDepth; i++) begin
      area_start[i] = cur + $urandom_range(max_gap);
      area_size[i]  = $urandom_range(max_size, 1);
      cur = area_start[i] + area_size[i];
      write_entry(OpWrArea, i[7:0], area_start[i], area_size[i], $urandom);
    end
    cur = $urandom;
    for (int i = 0; i < RegionDepth; i++) begin
      reg_start[i] = cur + $urandom_range(max_gap);
      reg_size[i]  = $urandom_range(max_size, 1);
      cur = reg_start[i] + reg_size[i];
      write_entry(OpWrRegion, i[7:0], reg_start[i], reg_size[i], $urandom);
    end
  endtask

  // random item: mostly aimed queries, some edge cases and noise
  task automatic random_item();
    int          kind, k;
    logic [31:0] st, sz, addr, len;
    logic [7:0]  off;
    logic [8:0]  cnt;
    kind = $urandom_range(99);
    off  = 8'($urandom);
    cnt  = ($urandom_range(3) == 0) ? 9'($urandom) : 9'($urandom_range(AreaDepth));
    if (kind < 60) begin
      if ($urandom_range(1)) begin
        k = $urandom_range(AreaDepth - 1);
        st = area_start[k];
        sz = area_size[k];
      end else begin
        k = $urandom_range(RegionDepth - 1);
        st = reg_start[k];
        sz = reg_size[k];
      end
      addr = st + $urandom_range(sz - 1);
      len  = $urandom_range(st + sz - addr + ($urandom_range(3) == 0 ? 2 : 0), 1);
      if ($urandom_range(1)) query(addr, len, 1'b1, off, cnt);
      else query(addr, len, 1'b0, off, cnt);
    end else if (kind < 80) begin
      query($urandom, $urandom, 1'($urandom_range(1)), off, 9'($urandom));
    end else if (kind < 88) begin
      query($urandom, $urandom_range(4), 1'($urandom_range(1)), 8'd0, 9'd256);
    end else if (kind < 93) begin
      k = $urandom_range(AreaDepth - 1);
      area_size[k] = $urandom_range(200, 1);
      write_entry(OpWrArea, k[7:0], area_start[k], area_size[k], $urandom);
    end else if (kind < 97) begin
      write_entry(OpWrRegion, 8'($urandom_range(255, RegionDepth)), $urandom, $urandom,
                  $urandom);
    end else begin
      push(2'd3, {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: tables, extremes and special cases
    build_tables(32'd0, 16, 64);
    set_region_count(7'd0);
    query(32'd0, 32'd1, 1'b0, 8'd0, 9'd0);            // empty region table
    query(area_start[0], 32'd1, 1'b1, 8'd0, 9'd0);    // empty window
    query(area_start[3], area_size[3], 1'b1, 8'd0, 9'd256);
    query(area_start[3], 32'd0, 1'b1, 8'd0, 9'd256);  // zero length wraps
    query(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 8'hFF, 9'h1FF);
    query(area_start[2], 32'd1, 1'b1, 8'd250, 9'd20); // window wraps
    query(area_start[100], 32'd2, 1'b1, 8'd0, 9'd300);
    write_entry(OpWrRegion, 8'd200, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF);
    push(2'd3, {192{1'b1}});
    write_entry(OpWrArea, 8'd255, 32'hFFFF_FFF0, 32'd0, 32'hFFFF_FFFF);
    area_size[255] = 32'd1;
    write_entry(OpWrArea, 8'd255, area_start[255], 32'd1, 32'h5A5A_A5A5);
    set_region_count(7'd64);
    query(reg_start[0], 32'd1, 1'b0, 8'd0, 9'd0);
    query(reg_start[63], reg_size[63], 1'b0, 8'd0, 9'd0);
    query(reg_start[63] + reg_size[63], 32'd1, 1'b0, 8'd0, 9'd0);
    query(32'd0, 32'd0, 1'b0, 8'd0, 9'd0);
    set_region_count(7'd127);
    query(reg_start[40], 32'd1, 1'b0, 8'd0, 9'd0);

    // random phase 1: slow receiver, with a long hold-off while sending
    tx_idle_pct = 34;
    rx_idle_pct = 84;
    for (int i = 0; i < 60; i++) begin
      if (i == 20) hold_len = 400;
      random_item();
    end

    // rebuild tables near the top of the address space so sums wrap
    set_region_count(7'($urandom_range(63, 1)));
    build_tables(32'hFFFF_0000, 1000, 4000);
    set_region_count(7'd64);

    // random phase 2: slow sender
    tx_idle_pct = 84;
    rx_idle_pct = 34;
    for (int i = 0; i < 60; i++) random_item();

    set_region_count(7'($urandom));

    // random phase 3: full rate
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    for (int i = 0; i < 40; i++) random_item();

    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (QuietCycles) @(posedge clk_i);

    $display("Covered %0d queries over both tables, table rebuilds, region counts",
             queries_sent);
    $display("from 0 to 127, and three backpressure phases in %0d cycles.", cycles);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d failures", fail_count);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- memory_range_region_check_top.f -----
rtl/mrrc_pkg.sv
rtl/mrrc_ram.sv
rtl/mrrc_front.sv
rtl/mrrc_back.sv
rtl/memory_range_region_check_top.sv
tb/mrrc_checker.sv
tb/memory_range_region_check_top_tb.sv
